[rtl/core/sits_pkg.sv]
// Shared constants and types for the stable index tiebreak sorter.
// No dependencies.
package sits_pkg;

   localparam int MAX_ITEMS = 64;
   localparam int KEY_WIDTH = 32;
   localparam int POS_WIDTH = 6;
   localparam int CNT_WIDTH = 7;

   typedef struct packed {
      logic                 load;       // input word accepted
      logic                 clear_set;  // set fully delivered
      logic                 prev_clear;
      logic                 best_clear;
      logic                 take_best;  // result word taken
      logic                 rd_en;
      logic [POS_WIDTH-1:0] rd_addr;
   } sits_cmd_type;

   typedef struct packed {
      logic [CNT_WIDTH-1:0] count;
   } sits_stat_type;

endpackage

[rtl/core/sits_ram.sv]
// Generic single write, single read RAM with registered read data.
// No dependencies.
module sits_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end
endmodule

[rtl/core/sits_dpath.sv]
// Datapath: key store, fill count, overflow mark, running minimum search.
// Depends on sits_pkg and sits_ram.
module sits_dpath (
   input  logic                           clock,
   input  logic                           reset,
   input  sits_pkg::sits_cmd_type         cmd,
   input  logic [sits_pkg::KEY_WIDTH-1:0] req_key,
   output sits_pkg::sits_stat_type        stat,
   output logic [sits_pkg::KEY_WIDTH-1:0] best_key,
   output logic [sits_pkg::POS_WIDTH-1:0] best_pos,
   output logic                           dropped
);
   import sits_pkg::*;

   logic [CNT_WIDTH-1:0] count_ff, count_in;
   logic                 drop_ff, drop_in;
   logic                 full;
   logic                 wr_en;
   logic [KEY_WIDTH-1:0] rd_data;
   logic                 rd_valid_ff;
   logic [POS_WIDTH-1:0] rd_idx_ff;
   logic [KEY_WIDTH-1:0] best_key_ff, prev_key_ff;
   logic [POS_WIDTH-1:0] best_pos_ff, prev_pos_ff;
   logic                 best_valid_ff, has_prev_ff;
   logic                 cand_ok, cand_better;

   // (key, position) order with keys signed
   function automatic logic before_pair(input logic [KEY_WIDTH-1:0] ka,
                                        input logic [POS_WIDTH-1:0] pa,
                                        input logic [KEY_WIDTH-1:0] kb,
                                        input logic [POS_WIDTH-1:0] pb);
      logic r;
      if (ka != kb) r = ($signed(ka) < $signed(kb));
      else          r = (pa < pb);
      return r;
   endfunction

   assign full  = (count_ff == CNT_WIDTH'(MAX_ITEMS));
   assign wr_en = cmd.load && !full;

   sits_ram #(.WIDTH(KEY_WIDTH), .DEPTH(MAX_ITEMS)) u_key_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[POS_WIDTH-1:0]),
      .wr_data (req_key),
      .rd_en   (cmd.rd_en),
      .rd_addr (cmd.rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      count_in = count_ff;
      drop_in  = drop_ff;
      if (cmd.clear_set) begin
         count_in = '0;
         drop_in  = 1'b0;
      end else if (cmd.load) begin
         if (full) drop_in  = 1'b1;
         else      count_in = count_ff + CNT_WIDTH'(1);
      end
   end

   assign cand_ok = !has_prev_ff ||
                    before_pair(prev_key_ff, prev_pos_ff, rd_data, rd_idx_ff);
   assign cand_better = cand_ok && (!best_valid_ff ||
                    before_pair(rd_data, rd_idx_ff, best_key_ff, best_pos_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         drop_ff       <= 1'b0;
         rd_valid_ff   <= 1'b0;
         best_valid_ff <= 1'b0;
         has_prev_ff   <= 1'b0;
      end else begin
         count_ff    <= count_in;
         drop_ff     <= drop_in;
         rd_valid_ff <= cmd.rd_en;
         if (cmd.best_clear) begin
            best_valid_ff <= 1'b0;
         end else if (rd_valid_ff && cand_better) begin
            best_valid_ff <= 1'b1;
         end
         if (cmd.prev_clear) begin
            has_prev_ff <= 1'b0;
         end else if (cmd.take_best) begin
            has_prev_ff <= 1'b1;
         end
      end
      rd_idx_ff <= cmd.rd_addr;
      if (rd_valid_ff && cand_better && !cmd.best_clear) begin
         best_key_ff <= rd_data;
         best_pos_ff <= rd_idx_ff;
      end
      if (cmd.take_best) begin
         prev_key_ff <= best_key_ff;
         prev_pos_ff <= best_pos_ff;
      end
   end

   assign stat.count = count_ff;
   assign best_key   = best_key_ff;
   assign best_pos   = best_pos_ff;
   assign dropped    = drop_ff;
endmodule

[rtl/core/sits_ctrl.sv]
// Controller: load, scan passes over the store, result handshake.
// Depends on sits_pkg.
module sits_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_last_item,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic                    last_out,
   input  sits_pkg::sits_stat_type stat,
   output sits_pkg::sits_cmd_type  cmd
);
   import sits_pkg::*;

   typedef enum logic [1:0] {ST_LOAD, ST_SCAN, ST_DRAIN, ST_SEND} state_type;

   state_type            state_ff;
   logic [POS_WIDTH-1:0] scan_idx_ff;
   logic [CNT_WIDTH-1:0] emit_cnt_ff;
   logic [CNT_WIDTH-1:0] last_idx;
   logic                 in_acc, out_acc, scan_end;

   assign last_idx  = stat.count - CNT_WIDTH'(1);
   assign req_ready = (state_ff == ST_LOAD);
   assign rsp_valid = (state_ff == ST_SEND);
   assign in_acc    = req_valid && req_ready;
   assign out_acc   = rsp_valid && rsp_ready;
   assign last_out  = (emit_cnt_ff == last_idx);
   assign scan_end  = ({1'b0, scan_idx_ff} == last_idx);

   always_comb begin
      cmd            = '0;
      cmd.load       = in_acc;
      cmd.prev_clear = in_acc && req_last_item;
      cmd.best_clear = (in_acc && req_last_item) || (out_acc && !last_out);
      cmd.take_best  = out_acc;
      cmd.clear_set  = out_acc && last_out;
      cmd.rd_en      = (state_ff == ST_SCAN);
      cmd.rd_addr    = scan_idx_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_LOAD;
         scan_idx_ff <= '0;
         emit_cnt_ff <= '0;
      end else begin
         unique case (state_ff)
            ST_LOAD: begin
               if (in_acc && req_last_item) begin
                  state_ff    <= ST_SCAN;
                  scan_idx_ff <= '0;
                  emit_cnt_ff <= '0;
               end
            end
            ST_SCAN: begin
               if (scan_end) state_ff <= ST_DRAIN;
               else          scan_idx_ff <= scan_idx_ff + POS_WIDTH'(1);
            end
            ST_DRAIN: begin
               state_ff <= ST_SEND;
            end
            ST_SEND: begin
               if (out_acc) begin
                  scan_idx_ff <= '0;
                  emit_cnt_ff <= emit_cnt_ff + CNT_WIDTH'(1);
                  state_ff    <= last_out ? ST_LOAD : ST_SCAN;
               end
            end
            default: state_ff <= ST_LOAD;
         endcase
      end
   end
endmodule

[rtl/core/stable_index_tiebreak_sorter.sv]
// Top level of the stable index tiebreak sorter.
// Depends on sits_pkg, sits_ctrl, sits_dpath (and sits_ram below it).
//
// Loads up to MAX_ITEMS signed keys, one word per cycle, tagging each with its
// arrival position; words past MAX_ITEMS are dropped and flagged. The word
// marked last starts output: results come in ascending (key, position) order.
// Each result is found by one scan of the key RAM (one read port, one entry
// per cycle), then a drain state and the result handshake. No input is taken
// while a set is draining.
module stable_index_tiebreak_sorter (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [sits_pkg::KEY_WIDTH-1:0] req_key,
   input  logic                           req_last_item,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [sits_pkg::KEY_WIDTH-1:0] rsp_sorted_key,
   output logic [sits_pkg::POS_WIDTH-1:0] rsp_original_position,
   output logic                           rsp_end_of_set,
   output logic                           rsp_overflow_flag
);
   import sits_pkg::*;

   sits_cmd_type  cmd;
   sits_stat_type stat;

   sits_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_last_item (req_last_item),
      .req_ready     (req_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .last_out      (rsp_end_of_set),
      .stat          (stat),
      .cmd           (cmd)
   );

   sits_dpath u_dpath (
      .clock    (clock),
      .reset    (reset),
      .cmd      (cmd),
      .req_key  (req_key),
      .stat     (stat),
      .best_key (rsp_sorted_key),
      .best_pos (rsp_original_position),
      .dropped  (rsp_overflow_flag)
   );
endmodule

[test/tb.sv]
// Testbench for stable_index_tiebreak_sorter: loads sets of signed keys, predicts the
// stable (key, position) ordering and checks every result word in order.
// Depends on sits_pkg and the sorter RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import sits_pkg::*;

   typedef struct {
      logic [KEY_WIDTH-1:0] key;
      logic [POS_WIDTH-1:0] pos;
      logic                 eos;
      logic                 ovf;
   } sorted_word_type;

   int errors = 0;

   task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
      $display("mismatch %s: got %0h expected %0h at %0t", what, got, exp, $realtime);
      errors++;
   endtask

   class sort_board;
      logic [KEY_WIDTH-1:0] held_key[MAX_ITEMS];
      int                   held_n = 0;
      bit                   dropped = 0;
      sorted_word_type      pending[$];

      function void note_word(logic [KEY_WIDTH-1:0] k, logic last);
         int ord[$];
         int j, t;
         sorted_word_type w;
         if (held_n < MAX_ITEMS) begin
            held_key[held_n] = k;
            held_n++;
         end else begin
            dropped = 1;
         end
         if (!last) return;
         for (int i = 0; i < held_n; i++) ord.push_back(i);
         // insertion sort: strict signed less only, so equal keys keep arrival order
         for (int i = 1; i < held_n; i++) begin
            t = ord[i];
            j = i;
            while (j > 0 && $signed(held_key[t]) < $signed(held_key[ord[j-1]])) begin
               ord[j] = ord[j-1];
               j--;
            end
            ord[j] = t;
         end
         for (int i = 0; i < held_n; i++) begin
            w.key = held_key[ord[i]];
            w.pos = POS_WIDTH'(ord[i]);
            w.eos = (i == held_n - 1);
            w.ovf = dropped;
            pending.push_back(w);
         end
         held_n = 0;
         dropped = 0;
      endfunction

      task check_word(logic [KEY_WIDTH-1:0] k, logic [POS_WIDTH-1:0] p, logic e, logic o);
         sorted_word_type w;
         if (pending.size() == 0) begin
            report("unexpected word", 64'(k), 64'(0));
            return;
         end
         w = pending.pop_front();
         if (k !== w.key) report("sorted_key", 64'(k), 64'(w.key));
         if (p !== w.pos) report("original_position", 64'(p), 64'(w.pos));
         if (e !== w.eos) report("end_of_set", 64'(e), 64'(w.eos));
         if (o !== w.ovf) report("overflow_flag", 64'(o), 64'(w.ovf));
      endtask
   endclass

   logic clock = 0, reset = 1;
   logic req_valid = 0, req_last_item = 0, rsp_ready = 0;
   logic [KEY_WIDTH-1:0] req_key = '0;
   logic req_ready, rsp_valid, rsp_end_of_set, rsp_overflow_flag;
   logic [KEY_WIDTH-1:0] rsp_sorted_key;
   logic [POS_WIDTH-1:0] rsp_original_position;

   stable_index_tiebreak_sorter u_top (.*);

   always #6 clock = ~clock;

   sort_board board = new();
   bit calm = 0;       // last part of run: no idling
   longint cycles = 0;

   always @(posedge clock) begin
      cycles++;
      if (cycles > 3000000) begin
         $display("tb failed");
         $finish;
      end
   end

   // result side: random stall bursts
   initial begin
      int burst;
      @(posedge clock iff !reset);
      forever begin
         if (!calm && $urandom_range(0, 3) == 0) begin
            burst = $urandom_range(1, 16);
            rsp_ready <= 0;
            repeat (burst) @(posedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         if (rsp_valid && rsp_ready)
            board.check_word(rsp_sorted_key, rsp_original_position, rsp_end_of_set,
                             rsp_overflow_flag);
      end
   end

   // valid stays up after acceptance; the next call either idles or drives the next word
   task automatic send_word(logic [KEY_WIDTH-1:0] k, logic last);
      if (!calm && $urandom_range(0, 5) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 16)) @(posedge clock);
      end
      req_valid <= 1;
      req_key <= k;
      req_last_item <= last;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_word(k, last);
   endtask

   function automatic logic [KEY_WIDTH-1:0] pick_key(int mode);
      case (mode)
         0: return $urandom_range(0, 3) - 2;                     // many ties
         1: return {1'b1, 31'h0} + ($urandom_range(0, 1) ? 0 : -1);
         default: return $urandom;
      endcase
   endfunction

   task automatic send_set(int n, int mode);
      for (int i = 0; i < n; i++) send_word(pick_key(mode), i == n - 1);
   endtask

   initial begin
      int n, sent;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: single value, extremes, ties, sign flips
      send_word(32'h8000_0000, 1);
      send_word(32'h7fff_ffff, 0);
      send_word(32'h8000_0000, 0);
      send_word(32'h0000_0000, 0);
      send_word(32'hffff_ffff, 0);
      send_word(32'h7fff_ffff, 0);
      send_word(32'h8000_0000, 1);
      send_word(32'h5555_5555, 0);
      send_word(32'haaaa_aaaa, 1);
      send_set(4, 0);
      req_valid <= 0;
      // hold off until every expected word has drained
      while (board.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      // full store plus dropped words, last one dropped too
      send_set(MAX_ITEMS + 3, 2);
      sent = 13 + MAX_ITEMS + 3;
      while (sent < 300 - MAX_ITEMS) begin
         n = ($urandom_range(0, 9) == 0) ? $urandom_range(40, MAX_ITEMS + 2)
                                         : $urandom_range(1, 10);
         if (sent > 250 - MAX_ITEMS) calm = 1;
         send_set(n, $urandom_range(0, 3));
         sent += n;
      end
      send_set(MAX_ITEMS, 0);
      req_valid <= 0;
      calm = 1;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0 && board.pending.size() == 0)
         $display("tb passed");
      else
         $display("tb failed");
      $finish;
   end
endmodule

[stable_index_tiebreak_sorter.f]
rtl/core/sits_pkg.sv
rtl/core/sits_ram.sv
rtl/core/sits_dpath.sv
rtl/core/sits_ctrl.sv
rtl/core/stable_index_tiebreak_sorter.sv
test/tb.sv
